### rtl/mssc_pkg.sv
// Package for the motor start/stop control unit: payload structs,
// configuration register layout, register indexes and reset values.
// No dependencies.
package mssc_pkg;

  localparam int unsigned TimerW  = 32;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ThreshW = 31;
  localparam int unsigned SpeedW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  localparam logic [SampleW-1:0] SampleTimeRst   = SampleW'(1);
  localparam logic [TimerW-1:0]  ShortLimitRst   = TimerW'(1000);
  localparam logic               CoastStopRst    = 1'b0;
  localparam logic [ThreshW-1:0] StopThreshRst   = ThreshW'(838860);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_TIME       = 2'd0,
    CFG_SHORT_PRESS_LIMIT = 2'd1,
    CFG_COAST_STOP        = 2'd2,
    CFG_STOP_SPEED_THRESH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_time;
    logic [TimerW-1:0]  short_press_limit;
    logic               coast_stop;
    logic [ThreshW-1:0] stop_speed_threshold;
  } cfg_t;

  typedef struct packed {
    logic                     manual_mode;
    logic                     protect_fault;
    logic                     start_button;
    logic                     stop_button;
    logic signed [SpeedW-1:0] speed_feedback;
    logic signed [SpeedW-1:0] speed_command;
  } in_t;

  typedef struct packed {
    logic                     alarm;
    logic                     run_indicator;
    logic signed [SpeedW-1:0] speed_reference;
    logic                     pwm_active;
    logic signed [SpeedW-1:0] speed_monitor;
  } out_t;

endpackage

### rtl/mssc_cfg_regs.sv
// Configuration register file of the motor start/stop control unit.
// Depends on mssc_pkg.
module mssc_cfg_regs
  import mssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_TIME:       cfg_nxt.sample_time          = cfg_data[SampleW-1:0];
        CFG_SHORT_PRESS_LIMIT: cfg_nxt.short_press_limit    = cfg_data[TimerW-1:0];
        CFG_COAST_STOP:        cfg_nxt.coast_stop           = cfg_data[0];
        CFG_STOP_SPEED_THRESH: cfg_nxt.stop_speed_threshold = cfg_data[ThreshW-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_time          <= SampleTimeRst;
      cfg_r.short_press_limit    <= ShortLimitRst;
      cfg_r.coast_stop           <= CoastStopRst;
      cfg_r.stop_speed_threshold <= StopThreshRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/mssc_core.sv
// Start/stop sequencing: press timer, run/stop flags and the result of one
// sample, computed from the staged beat and committed on advance.
// Depends on mssc_pkg.
module mssc_core
  import mssc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  in_t  item,
  input  logic advance,
  output out_t result
);

  logic [TimerW-1:0] press_timer_r, press_timer_nxt;
  logic              timing_r, timing_nxt;
  logic              stopping_r, stopping_nxt;
  logic              pwm_r, pwm_nxt;
  logic              alarm_r, alarm_nxt;
  logic              run_r, run_nxt;
  logic [SpeedW-1:0] ref_r, ref_nxt;
  logic [SpeedW-1:0] mon_r, mon_nxt;

  logic [TimerW:0]   timer_sum;
  logic [TimerW-1:0] timer_upd;
  logic              short_press;
  logic [SpeedW-1:0] fb_bits;
  logic [SpeedW-1:0] fb_mag;
  logic              below_thresh;

  always_comb begin
    timer_sum    = {1'b0, press_timer_r} + {{(TimerW+1-SampleW){1'b0}}, cfg.sample_time};
    if (!timing_r) begin
      timer_upd = '0;
    end else if (timer_sum[TimerW]) begin
      timer_upd = '1;
    end else begin
      timer_upd = timer_sum[TimerW-1:0];
    end
    short_press  = (timer_upd != '0) && (timer_upd < cfg.short_press_limit);
    fb_bits      = item.speed_feedback;
    fb_mag       = fb_bits[SpeedW-1] ? (~fb_bits + SpeedW'(1)) : fb_bits;
    below_thresh = fb_mag < {1'b0, cfg.stop_speed_threshold};
  end

  always_comb begin
    press_timer_nxt = press_timer_r;
    timing_nxt      = timing_r;
    stopping_nxt    = stopping_r;
    pwm_nxt         = pwm_r;
    alarm_nxt       = alarm_r;
    run_nxt         = run_r;
    ref_nxt         = ref_r;
    mon_nxt         = mon_r;
    if (!item.manual_mode) begin
      press_timer_nxt = timer_upd;
      mon_nxt         = item.speed_feedback;
      if (item.protect_fault) begin
        timing_nxt = 1'b0;
        alarm_nxt  = 1'b1;
        run_nxt    = 1'b0;
        ref_nxt    = '0;
        pwm_nxt    = 1'b0;
      end else begin
        alarm_nxt = 1'b0;
        if (pwm_r && stopping_r) begin
          ref_nxt = '0;
          if (below_thresh) begin
            pwm_nxt      = 1'b0;
            stopping_nxt = 1'b0;
          end
          if (item.start_button) begin
            timing_nxt = 1'b1;
          end else begin
            if (short_press) begin
              pwm_nxt      = 1'b1;
              stopping_nxt = 1'b0;
            end
            timing_nxt = 1'b0;
          end
        end else if (pwm_r) begin
          ref_nxt = item.speed_command;
          run_nxt = 1'b1;
          if (item.stop_button) begin
            timing_nxt = 1'b1;
          end else begin
            if (short_press) begin
              if (cfg.coast_stop) begin
                pwm_nxt = 1'b0;
              end else begin
                stopping_nxt = 1'b1;
              end
            end
            timing_nxt = 1'b0;
          end
        end else begin
          ref_nxt = '0;
          run_nxt = 1'b0;
          if (item.start_button) begin
            timing_nxt = 1'b1;
          end else begin
            if (short_press) begin
              pwm_nxt = 1'b1;
            end
            timing_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign result.alarm           = alarm_nxt;
  assign result.run_indicator   = run_nxt;
  assign result.speed_reference = ref_nxt;
  assign result.pwm_active      = pwm_nxt;
  assign result.speed_monitor   = mon_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_timer_r <= '0;
      timing_r      <= 1'b0;
      stopping_r    <= 1'b0;
      pwm_r         <= 1'b0;
      alarm_r       <= 1'b0;
      run_r         <= 1'b0;
      ref_r         <= '0;
      mon_r         <= '0;
    end else if (advance) begin
      press_timer_r <= press_timer_nxt;
      timing_r      <= timing_nxt;
      stopping_r    <= stopping_nxt;
      pwm_r         <= pwm_nxt;
      alarm_r       <= alarm_nxt;
      run_r         <= run_nxt;
      ref_r         <= ref_nxt;
      mon_r         <= mon_nxt;
    end
  end

endmodule

### rtl/motor_start_stop_control_unit.sv
// Top level of the motor start/stop control unit: input register, sequencing
// core, result register and configuration registers.
// Depends on mssc_pkg, mssc_cfg_regs and mssc_core.
//
//   channel  ports                          direction  beat
//   in       in_valid in_stall in_data      input      one drive sample
//   out      out_valid out_stall out_data   output     one result per sample
//   cfg      cfg_valid cfg_ready cfg_index  input      one register write
//            cfg_data
//
// One beat per cycle sustained while out_stall is low; an accepted sample goes
// through the input register into the result register, which raises out_valid.
// rst_n is synchronous: drops both registers and restores state and
// configuration reset values.
// out_stall holds the result register; the input register then holds and
// in_stall rises only when it is full and cannot advance.
module motor_start_stop_control_unit
  import mssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data
);

  cfg_t cfg;
  in_t  stage_r;
  logic stage_vld_r;
  out_t out_r;
  logic out_vld_r;
  out_t result;
  logic advance;
  logic in_take;

  mssc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = stage_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stage_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  mssc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (stage_r),
    .advance (advance),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (in_take) begin
        stage_vld_r <= 1'b1;
      end else if (advance) begin
        stage_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### test/motor_start_stop_control_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for motor_start_stop_control_unit: directed and random drive samples with
// a behavioral start/stop predictor, result scoreboard and stall/idle pressure.
// Depends on mssc_pkg and the motor_start_stop_control_unit RTL.
module motor_start_stop_control_unit_tb;
  import mssc_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned DrainTail  = 4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;

  cfg_t               cfg_model = '{SampleTimeRst, ShortLimitRst, CoastStopRst, StopThreshRst};
  logic [TimerW-1:0]  press_count = '0;
  logic               timing_press = 1'b0;
  logic               ramp_stopping = 1'b0;
  logic               pwm_model = 1'b0;
  logic               alarm_model = 1'b0;
  logic               run_model = 1'b0;
  logic [SpeedW-1:0]  ref_model = '0;
  logic [SpeedW-1:0]  monitor_model = '0;

  out_t               expected_outputs[$];
  int unsigned        samples_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        cfg_writes = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        mismatches = 0;

  motor_start_stop_control_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_t next_drive_outputs(input in_t s);
    logic [TimerW:0]   sum;
    logic [SpeedW-1:0] mag;
    logic              short_press;
    out_t              r;
    if (!s.manual_mode) begin
      if (timing_press) begin
        sum = {1'b0, press_count} + (TimerW + 1)'(cfg_model.sample_time);
        press_count = sum[TimerW] ? '1 : sum[TimerW-1:0];
      end else begin
        press_count = '0;
      end
      short_press = (press_count != '0) && (press_count < cfg_model.short_press_limit);
      mag = s.speed_feedback[SpeedW-1] ? SpeedW'(-s.speed_feedback) : SpeedW'(s.speed_feedback);
      monitor_model = s.speed_feedback;
      if (s.protect_fault) begin
        timing_press = 1'b0;
        alarm_model = 1'b1;
        run_model = 1'b0;
        ref_model = '0;
        pwm_model = 1'b0;
      end else begin
        alarm_model = 1'b0;
        if (pwm_model && ramp_stopping) begin
          ref_model = '0;
          if (mag < {1'b0, cfg_model.stop_speed_threshold}) begin
            pwm_model = 1'b0;
            ramp_stopping = 1'b0;
          end
          if (s.start_button) begin
            timing_press = 1'b1;
          end else begin
            if (short_press) begin
              pwm_model = 1'b1;
              ramp_stopping = 1'b0;
            end
            timing_press = 1'b0;
          end
        end else if (pwm_model) begin
          ref_model = s.speed_command;
          run_model = 1'b1;
          if (s.stop_button) begin
            timing_press = 1'b1;
          end else begin
            if (short_press) begin
              if (cfg_model.coast_stop) pwm_model = 1'b0;
              else ramp_stopping = 1'b1;
            end
            timing_press = 1'b0;
          end
        end else begin
          ref_model = '0;
          run_model = 1'b0;
          if (s.start_button) begin
            timing_press = 1'b1;
          end else begin
            if (short_press) pwm_model = 1'b1;
            timing_press = 1'b0;
          end
        end
      end
    end
    r.alarm = alarm_model;
    r.run_indicator = run_model;
    r.speed_reference = ref_model;
    r.pwm_active = pwm_model;
    r.speed_monitor = monitor_model;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [SpeedW-1:0] want,
                               input logic [SpeedW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    out_t want;
    logic busy;
    busy = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        cfg_writes++;
        case (cfg_index)
          CFG_SAMPLE_TIME:       cfg_model.sample_time = cfg_data[SampleW-1:0];
          CFG_SHORT_PRESS_LIMIT: cfg_model.short_press_limit = cfg_data;
          CFG_COAST_STOP:        cfg_model.coast_stop = cfg_data[0];
          CFG_STOP_SPEED_THRESH: cfg_model.stop_speed_threshold = cfg_data[ThreshW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        expected_outputs.push_back(next_drive_outputs(in_data));
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        results_seen++;
        if (expected_outputs.size() == 0) begin
          $error("result beat with no sample pending");
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          compare_field("alarm", SpeedW'(want.alarm), SpeedW'(out_data.alarm));
          compare_field("run_indicator", SpeedW'(want.run_indicator),
                        SpeedW'(out_data.run_indicator));
          compare_field("speed_reference", want.speed_reference, out_data.speed_reference);
          compare_field("pwm_active", SpeedW'(want.pwm_active), SpeedW'(out_data.pwm_active));
          compare_field("speed_monitor", want.speed_monitor, out_data.speed_monitor);
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat for %0d cycles", QuietLimit);
        $display("motor_start_stop_control_unit_tb: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic in_t make_sample(input logic manual, input logic fault,
                                      input logic start, input logic stop,
                                      input logic signed [SpeedW-1:0] fb,
                                      input logic signed [SpeedW-1:0] cmd);
    in_t s;
    s.manual_mode = manual;
    s.protect_fault = fault;
    s.start_button = start;
    s.stop_button = stop;
    s.speed_feedback = fb;
    s.speed_command = cmd;
    return s;
  endfunction

  function automatic logic signed [SpeedW-1:0] rand_speed();
    logic [SpeedW-1:0] mag;
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return -32'sh7FFF_FFFF;
      2, 3, 4: begin
        mag = $urandom_range(32'(cfg_model.stop_speed_threshold) + 32'd2, 0);
        return $urandom_range(1) ? -$signed(mag) : $signed(mag);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  // hold a button for some samples, then release it
  task automatic press(input logic on_stop, input int unsigned held,
                       input logic signed [SpeedW-1:0] fb);
    repeat (held) send_sample(make_sample(1'b0, 1'b0, !on_stop, on_stop, fb, $urandom));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, fb, $urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen != samples_sent) @(posedge clk);
    repeat (DrainTail) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDatW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [SampleW-1:0] step, input logic [TimerW-1:0] limit,
                            input logic coast, input logic [CfgDatW-1:0] thresh);
    drain();
    write_reg(CFG_SAMPLE_TIME, {16'($urandom), step});
    write_reg(CFG_SHORT_PRESS_LIMIT, limit);
    write_reg(CFG_COAST_STOP, {31'($urandom), coast});
    write_reg(CFG_STOP_SPEED_THRESH, thresh);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_start_and_ramp_stop();
    logic signed [SpeedW-1:0] thr;
    thr = $signed({1'b0, StopThreshRst});
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sh7FFF_FFFF));
    press(1'b0, 2, 32'sh7FFF_FFFF);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, -32'sh7FFF_FFFF, 32'sh8000_0000));
    press(1'b1, 1, 32'sh7FFF_FFFF);
    // most negative feedback and a magnitude equal to the threshold never end the ramp
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sh8000_0000, $urandom));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, -thr, $urandom));
    press(1'b0, 1, thr);
    press(1'b1, 1, 32'sh0100_0000);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, -(thr - 32'sd1), $urandom));
    send_sample(make_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'sh1234_5678, $urandom));
    press(1'b0, 1, 32'sh0100_0000);
    press(1'b1, 1, 32'sh0100_0000);
    // fault keeps the stopping flag, so the next start re-enters the ramp
    send_sample(make_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'sh0100_0000, $urandom));
    press(1'b0, 1, 32'sh0100_0000);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, $urandom));
  endtask

  task automatic test_config_extremes();
    set_config(16'd0, 32'hFFFF_FFFF, 1'b1, 32'd0);
    press(1'b0, 3, 32'sd0);
    set_config(16'hFFFF, 32'd0, 1'b1, 32'hFFFF_FFFF);
    press(1'b0, 1, 32'sd0);
    set_config(16'd5, 32'd12, 1'b1, 32'h7FFF_FFFF);
    press(1'b0, 2, 32'sh7FFF_FFFF);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sh7FFF_FFFF, $urandom));
    press(1'b1, 1, 32'sh7FFF_FFFF);
    press(1'b0, 3, 32'sd0);
    set_config(16'd1, 32'd1000, 1'b0, 32'hFFFF_FFFF);
    press(1'b0, 1, 32'sh7FFF_FFFF);
    press(1'b1, 1, 32'sh7FFF_FFFF);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sh8000_0001, $urandom));
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sh7FFF_FFFE, $urandom));
    set_config(16'd1, 32'd1000, 1'b0, 32'd0);
    press(1'b0, 1, 32'sd0);
    press(1'b1, 1, 32'sd0);
    send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, $urandom));
    send_sample(make_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'sd0, $urandom));
  endtask

  task automatic test_random_drive(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned held;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        held = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
        press(1'($urandom_range(1)), held, rand_speed());
      end else if (pick < 75) begin
        repeat ($urandom_range(4, 1))
          send_sample(make_sample(1'b0, 1'b0, 1'b0, 1'b0, rand_speed(), $urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(2, 1))
          send_sample(make_sample(1'b0, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                  rand_speed(), $urandom));
      end else if (pick < 92) begin
        repeat ($urandom_range(3, 1))
          send_sample(make_sample(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), $urandom, $urandom));
      end else begin
        send_sample(make_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 1'($urandom_range(1)),
                                $urandom, $urandom));
      end
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    logic [SampleW-1:0] step;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 63;
    test_start_and_ramp_stop();
    test_config_extremes();

    set_config(16'd1, $urandom_range(12, 3), 1'b0, 32'h0100_0000);
    send_idle_pct = 24;
    recv_idle_pct = 63;
    test_random_drive(570);

    step = SampleW'($urandom_range(2000, 100));
    set_config(step, step * $urandom_range(8, 2), 1'b1, $urandom);
    send_idle_pct = 63;
    recv_idle_pct = 24;
    test_random_drive(570);

    set_config(SampleW'($urandom), $urandom, 1'($urandom_range(1)), $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_drive(570);

    drain();
    $display("Drove %0d samples and checked %0d results across %0d register writes:",
             samples_sent, results_seen, cfg_writes);
    $display("  start/stop and ramp sequences, register extremes, random mix.");
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("motor_start_stop_control_unit_tb: PASS");
    end else begin
      $display("motor_start_stop_control_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
